>>> rtl/core/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

	localparam int DEPTH   = 128;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 8;
	localparam int CAP_W   = 8;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

	typedef enum logic [1:0] {
		ACT_ENQ  = 2'd0,
		ACT_DEQ  = 2'd1,
		ACT_PEEK = 2'd2,
		ACT_NOP  = 2'd3
	} spq_action_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RSVD  = 2'd3
	} spq_status_t;

	typedef struct packed {
		logic                    insert;
		logic                    shift;
		logic signed [VAL_W-1:0] data;
	} spq_cell_ctrl_t;

endpackage

>>> rtl/core/spq_req_if.sv
// Request channel: action and value to insert.
`timescale 1ns / 1ps
interface spq_req_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     action;
	logic signed [spq_pkg::VAL_W-1:0] value_in;

	modport source (output valid, output action, output value_in, input ready);
	modport sink (input valid, input action, input value_in, output ready);
endinterface

>>> rtl/core/spq_rsp_if.sv
// Response channel: value, status and occupancy.
`timescale 1ns / 1ps
interface spq_rsp_if;
	logic                             valid;
	logic                             ready;
	logic signed [spq_pkg::VAL_W-1:0] value_out;
	logic [1:0]                       status;
	logic [spq_pkg::CNT_W-1:0]        occupancy;

	modport source (output valid, output value_out, output status, output occupancy,
		input ready);
	modport sink (input valid, input value_out, input status, input occupancy,
		output ready);
endinterface

>>> rtl/core/spq_cfg_if.sv
// Configuration write channel for the capacity register.
`timescale 1ns / 1ps
interface spq_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [spq_pkg::CAP_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/spq_cell.sv
// One storage cell of the sorted row: compare, shift in from either side, or hold.
`timescale 1ns / 1ps
module spq_cell (
	input  logic                             clk,
	input  spq_pkg::spq_cell_ctrl_t          ctrl,
	input  logic                             occ,
	input  logic                             tail,
	input  logic                             left_greater,
	input  logic signed [spq_pkg::VAL_W-1:0] left_value,
	input  logic signed [spq_pkg::VAL_W-1:0] right_value,
	output logic signed [spq_pkg::VAL_W-1:0] value,
	output logic                             greater
);
	import spq_pkg::*;

	logic signed [VAL_W-1:0] value_q;
	logic signed [VAL_W-1:0] value_d;

	assign greater = occ && (value_q > ctrl.data);
	assign value   = value_q;

	always_comb begin
		value_d = value_q;
		if (ctrl.insert) begin
			if (left_greater) begin
				value_d = left_value;
			end else if (greater || tail) begin
				value_d = ctrl.data;
			end
		end else if (ctrl.shift) begin
			value_d = right_value;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end
endmodule

>>> rtl/core/spq_chain.sv
// Row of storage cells kept in ascending order; the head cell holds the minimum.
`timescale 1ns / 1ps
module spq_chain (
	input  logic                             clk,
	input  spq_pkg::spq_cell_ctrl_t          ctrl,
	input  logic [spq_pkg::CNT_W-1:0]        count,
	output logic signed [spq_pkg::VAL_W-1:0] head
);
	import spq_pkg::*;

	logic signed [VAL_W-1:0] cell_value [DEPTH];
	logic                    cell_greater [DEPTH];

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic                    occ;
			logic                    tail;
			logic                    lg;
			logic signed [VAL_W-1:0] lv;
			logic signed [VAL_W-1:0] rv;

			assign occ  = 32'(i) < 32'(count);
			assign tail = 32'(i) == 32'(count);

			if (i == 0) begin : g_first
				assign lg = 1'b0;
				assign lv = '0;
			end else begin : g_mid
				assign lg = cell_greater[i-1];
				assign lv = cell_value[i-1];
			end

			if (i == DEPTH - 1) begin : g_last
				assign rv = cell_value[i];
			end else begin : g_inner
				assign rv = cell_value[i+1];
			end

			spq_cell u_cell (
				.clk          (clk),
				.ctrl         (ctrl),
				.occ          (occ),
				.tail         (tail),
				.left_greater (lg),
				.left_value   (lv),
				.right_value  (rv),
				.value        (cell_value[i]),
				.greater      (cell_greater[i])
			);
		end
	endgenerate

	assign head = cell_value[0];
endmodule

>>> rtl/core/sorted_priority_queue_unit.sv
// Sorted min-priority queue built on a row of compare-and-shift cells.
`timescale 1ns / 1ps
// Each request (enqueue, dequeue or peek) yields exactly one response in the cycle after
// it is taken, and a new request is taken whenever the response register is empty or
// being drained, so the queue sustains one request per cycle. That figure is set by the
// row of storage cells: an enqueue broadcasts its value to every cell, each cell compares
// against it and shifts in one step, and a dequeue shifts the whole row toward the head
// in one step. Ties leave in arrival order. The store needs no clearing after reset; only
// cells below the count are ever read. Write capacity through the configuration channel
// only while the queue is idle; the block does not enforce this. It is clipped to DEPTH.
module sorted_priority_queue_unit (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp,
	spq_cfg_if.sink   cfg
);
	import spq_pkg::*;

	logic [CAP_W-1:0]        cap_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_d;
	logic                    rsp_valid_q;
	logic signed [VAL_W-1:0] value_q;
	spq_status_t             status_q;
	logic [CNT_W-1:0]        occ_q;

	logic                    take;
	logic                    full;
	logic                    empty;
	spq_action_t             act;
	spq_cell_ctrl_t          ctrl;
	logic signed [VAL_W-1:0] head;
	logic signed [VAL_W-1:0] value_d;
	spq_status_t             status_d;

	assign cfg.ready = 1'b1;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign take      = req.valid && req.ready;
	assign act       = spq_action_t'(req.action);
	assign full      = (32'(count_q) >= 32'(cap_q)) || (32'(count_q) >= DEPTH);
	assign empty     = count_q == '0;

	always_comb begin
		ctrl.insert = 1'b0;
		ctrl.shift  = 1'b0;
		ctrl.data   = req.value_in;
		value_d     = '0;
		status_d    = ST_DONE;
		count_d     = count_q;
		case (act)
			ACT_ENQ: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.insert = take;
					count_d     = count_q + CNT_W'(1);
				end
			end
			ACT_DEQ: begin
				if (empty) begin
					value_d  = -32'sd1;
					status_d = ST_EMPTY;
				end else begin
					value_d     = head;
					ctrl.shift  = take;
					count_d     = count_q - CNT_W'(1);
				end
			end
			ACT_PEEK: begin
				if (empty) begin
					value_d  = -32'sd1;
					status_d = ST_EMPTY;
				end else begin
					value_d = head;
				end
			end
			default: begin
				value_d = '0;
			end
		endcase
	end

	spq_chain u_chain (
		.clk   (clk),
		.ctrl  (ctrl),
		.count (count_q),
		.head  (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				cap_q <= cfg.data;
			end
			if (take) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			value_q  <= value_d;
			status_q <= status_d;
			occ_q    <= count_d;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.value_out = value_q;
	assign rsp.status    = status_q;
	assign rsp.occupancy = occ_q;
endmodule

>>> rtl/core/spq_checker.sv
// Port-level assertions for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps
module spq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic signed [spq_pkg::VAL_W-1:0] rsp_value_out,
	input logic [1:0]                       rsp_status,
	input logic [spq_pkg::CNT_W-1:0]        rsp_occupancy
);
	import spq_pkg::*;

	a_req_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("request taken without a response in the next cycle");

	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_EMPTY) |->
			(rsp_value_out == -32'sd1) && (rsp_occupancy == '0))
		else $error("empty response must carry -1 and zero occupancy");

	a_full_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_FULL) |-> (rsp_value_out == '0))
		else $error("full response must carry zero value");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_out))
		else $error("stalled response dropped or changed");
endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_value_out (rsp.value_out),
	.rsp_status    (rsp.status),
	.rsp_occupancy (rsp.occupancy)
);
